@@ hdl/kbb_pkg.sv @@
// Shared constants and configuration register codes for the blob profile evaluator.
`default_nettype none

package kbb_pkg;

  localparam int RADIUS_W    = 22;
  localparam int SR_W        = 20;
  localparam int ORD_W       = 3;
  localparam int ALPHA_W     = 21;
  localparam int BLOB_W      = 17;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 21;
  localparam int A2_W        = 2 * SR_W;

  localparam int MAX_ORDER   = 7;
  localparam int DIV_SPS     = 2;
  localparam int SER_DIGITS  = 8;

  localparam int NUM_TERMS_DEF = 40;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 21'd1048576;
  localparam logic [BLOB_W-1:0]  BLOB_ONE  = 17'd65536;

  localparam logic [SR_W-1:0]    SR_RESET    = 20'd131072;
  localparam logic [ORD_W-1:0]   ORD_RESET   = 3'd2;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 21'd235930;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SUPPORT_RADIUS  = 2'd0,
    CFG_BESSEL_ORDER    = 2'd1,
    CFG_DENSITY_FALLOFF = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/kbb_frac_div.sv @@
// Pipelined restoring divider giving floor(num * 2^FB / den) for num <= den.
`default_nettype none

module kbb_frac_div
  import kbb_pkg::*;
#(
  parameter int NW  = 40,
  parameter int FB  = 32,
  parameter int SPS = DIV_SPS,
  parameter int SW  = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [NW-1:0] den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [FB:0]        quo,
  output logic [SW-1:0]      out_side
);

  localparam int STEPS = FB + 1;
  localparam int NST   = (STEPS + SPS - 1) / SPS;
  localparam int RW    = NW + 1;
  localparam int QW    = FB + 1;

  logic          s_valid [NST+1];
  logic [RW-1:0] s_rem   [NST+1];
  logic [QW-1:0] s_q     [NST+1];
  logic [NW-1:0] s_den   [NST+1];
  logic [SW-1:0] s_side  [NST+1];

  assign s_valid[0] = in_valid;
  assign s_rem[0]   = {1'b0, num};
  assign s_q[0]     = '0;
  assign s_den[0]   = den;
  assign s_side[0]  = in_side;

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic          valid_r;
    logic [RW-1:0] rem_r;
    logic [RW-1:0] rem_nxt;
    logic [QW-1:0] q_r;
    logic [QW-1:0] q_nxt;
    logic [NW-1:0] den_r;
    logic [SW-1:0] side_r;

    always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      int s;
      r = s_rem[g];
      q = s_q[g];
      for (int j = 0; j < SPS; j++) begin
        s = g * SPS + j;
        if (s < STEPS) begin
          if (s != 0) r = {r[RW-2:0], 1'b0};
          if (r >= {1'b0, s_den[g]}) begin
            r = r - {1'b0, s_den[g]};
            q = {q[QW-2:0], 1'b1};
          end else begin
            q = {q[QW-2:0], 1'b0};
          end
        end
      end
      rem_nxt = r;
      q_nxt   = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= s_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        q_r    <= q_nxt;
        den_r  <= s_den[g];
        side_r <= s_side[g];
      end
    end

    assign s_valid[g+1] = valid_r;
    assign s_rem[g+1]   = rem_r;
    assign s_q[g+1]     = q_r;
    assign s_den[g+1]   = den_r;
    assign s_side[g+1]  = side_r;
  end

  assign out_valid = s_valid[NST];
  assign quo       = s_q[NST];
  assign out_side  = s_side[NST];

endmodule

`default_nettype wire

@@ hdl/kbb_sqrt.sv @@
// Pipelined floor square root of a Q.2W value, two result bits per stage.
`default_nettype none

module kbb_sqrt #(
  parameter int FRAC_BITS = 16,
  parameter int SW        = 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [2*FRAC_BITS:0]   val,
  input  wire logic [SW-1:0]          in_side,
  output logic                        out_valid,
  output logic [FRAC_BITS:0]          root,
  output logic [SW-1:0]               out_side
);

  localparam int W     = FRAC_BITS;
  localparam int PADW  = 2 * W + 2;
  localparam int NSTEP = W + 1;
  localparam int SPS   = 2;
  localparam int NST   = (NSTEP + SPS - 1) / SPS;
  localparam int RW    = W + 4;
  localparam int ROW   = W + 1;

  logic            s_valid [NST+1];
  logic [PADW-1:0] s_val   [NST+1];
  logic [RW-1:0]   s_rem   [NST+1];
  logic [ROW-1:0]  s_root  [NST+1];
  logic [SW-1:0]   s_side  [NST+1];

  assign s_valid[0] = in_valid;
  assign s_val[0]   = {1'b0, val};
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;
  assign s_side[0]  = in_side;

  for (genvar g = 0; g < NST; g++) begin : g_stage
    logic            valid_r;
    logic [PADW-1:0] val_r;
    logic [PADW-1:0] val_nxt;
    logic [RW-1:0]   rem_r;
    logic [RW-1:0]   rem_nxt;
    logic [ROW-1:0]  root_r;
    logic [ROW-1:0]  root_nxt;
    logic [SW-1:0]   side_r;

    always_comb begin
      logic [PADW-1:0] v;
      logic [RW-1:0]   r;
      logic [ROW-1:0]  rt;
      logic [RW-1:0]   trial;
      v  = s_val[g];
      r  = s_rem[g];
      rt = s_root[g];
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < NSTEP) begin
          r     = {r[RW-3:0], v[PADW-1:PADW-2]};
          v     = {v[PADW-3:0], 2'b00};
          trial = RW'({rt, 2'b01});
          if (r >= trial) begin
            r  = r - trial;
            rt = {rt[ROW-2:0], 1'b1};
          end else begin
            rt = {rt[ROW-2:0], 1'b0};
          end
        end
      end
      val_nxt  = v;
      rem_nxt  = r;
      root_nxt = rt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= s_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        val_r  <= val_nxt;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        side_r <= s_side[g];
      end
    end

    assign s_valid[g+1] = valid_r;
    assign s_val[g+1]   = val_r;
    assign s_rem[g+1]   = rem_r;
    assign s_root[g+1]  = root_r;
    assign s_side[g+1]  = side_r;
  end

  assign out_valid = s_valid[NST];
  assign root      = s_root[NST];
  assign out_side  = s_side[NST];

endmodule

`default_nettype wire

@@ hdl/kbb_series.sv @@
// Pipelined normalized Bessel series: one multiply, one add and a long division per term.
`default_nettype none

module kbb_series
  import kbb_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NUM_TERMS = NUM_TERMS_DEF,
  parameter int SW        = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic [ORD_W-1:0]      order,
  input  wire logic                  in_valid,
  input  wire logic [FRAC_BITS+4:0]  y,
  input  wire logic [SW-1:0]         in_side,
  output logic                       out_valid,
  output logic [FRAC_BITS+19:0]      sum,
  output logic [SW-1:0]              out_side
);

  localparam int W    = FRAC_BITS;
  localparam int YW   = W + 5;
  localparam int Q4W  = W + 7;
  localparam int TW   = W + 18;
  localparam int SUMW = W + 20;
  localparam int HW   = (TW + 1) / 2;
  localparam int PMW  = HW + Q4W;
  localparam int FW   = TW + Q4W;
  localparam int PW   = W + 25;
  localparam int NDS  = (PW + SER_DIGITS - 1) / SER_DIGITS;
  localparam int PWP  = NDS * SER_DIGITS;
  localparam int NT   = NUM_TERMS - 1;
  localparam int DB   = $clog2(NT * (NT + MAX_ORDER) + 1);

  // series entry points: index k feeds term k, index NT is the last term
  logic            e_valid [NT+1];
  logic [TW-1:0]   e_term  [NT+1];
  logic [SUMW-1:0] e_sum   [NT+1];
  logic [Q4W-1:0]  e_q4    [NT+1];
  logic [SW-1:0]   e_side  [NT+1];

  logic [2*YW-1:0] ysq;
  logic            f_valid_r;
  logic [Q4W-1:0]  f_q4_r;
  logic [SW-1:0]   f_side_r;

  assign ysq = (2*YW)'(y) * (2*YW)'(y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_q4_r   <= Q4W'(ysq >> (W + 2));
      f_side_r <= in_side;
    end
  end

  assign e_valid[0] = f_valid_r;
  assign e_term[0]  = TW'(1) << W;
  assign e_sum[0]   = '0;
  assign e_q4[0]    = f_q4_r;
  assign e_side[0]  = f_side_r;

  for (genvar k = 0; k < NT; k++) begin : g_term
    localparam int K1 = k + 1;

    logic            m_valid_r;
    logic [PMW-1:0]  m_phi_r;
    logic [PMW-1:0]  m_plo_r;
    logic [SUMW-1:0] m_sum_r;
    logic [Q4W-1:0]  m_q4_r;
    logic [SW-1:0]   m_side_r;

    logic            a_valid_r;
    logic [PWP-1:0]  a_num_r;
    logic [SUMW-1:0] a_sum_r;
    logic [Q4W-1:0]  a_q4_r;
    logic [SW-1:0]   a_side_r;
    logic [FW-1:0]   prod_full;

    logic [DB-1:0]   dv;

    logic            d_valid [NDS+1];
    logic [PWP-1:0]  d_num   [NDS+1];
    logic [DB-1:0]   d_rem   [NDS+1];
    logic [SUMW-1:0] d_sum   [NDS+1];
    logic [Q4W-1:0]  d_q4    [NDS+1];
    logic [SW-1:0]   d_side  [NDS+1];

    assign dv = DB'(K1 * (K1 + int'(order)));

    // multiply stage: split the term so each product stays narrow
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_valid_r <= 1'b0;
      end else if (en) begin
        m_valid_r <= e_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_phi_r  <= PMW'(e_term[k][TW-1:HW]) * PMW'(e_q4[k]);
        m_plo_r  <= PMW'(e_term[k][HW-1:0]) * PMW'(e_q4[k]);
        m_sum_r  <= e_sum[k] + SUMW'(e_term[k]);
        m_q4_r   <= e_q4[k];
        m_side_r <= e_side[k];
      end
    end

    assign prod_full = (FW'(m_phi_r) << HW) + FW'(m_plo_r);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_valid_r <= 1'b0;
      end else if (en) begin
        a_valid_r <= m_valid_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_num_r  <= PWP'(prod_full >> W);
        a_sum_r  <= m_sum_r;
        a_q4_r   <= m_q4_r;
        a_side_r <= m_side_r;
      end
    end

    assign d_valid[0] = a_valid_r;
    assign d_num[0]   = a_num_r;
    assign d_rem[0]   = '0;
    assign d_sum[0]   = a_sum_r;
    assign d_q4[0]    = a_q4_r;
    assign d_side[0]  = a_side_r;

    // long division by the small per-term divisor, quotient shifts in from the bottom
    for (genvar j = 0; j < NDS; j++) begin : g_div
      logic            valid_r;
      logic [PWP-1:0]  num_r;
      logic [PWP-1:0]  num_nxt;
      logic [DB-1:0]   rem_r;
      logic [DB-1:0]   rem_nxt;
      logic [SUMW-1:0] sum_r;
      logic [Q4W-1:0]  q4_r;
      logic [SW-1:0]   side_r;

      always_comb begin
        logic [PWP-1:0] n;
        logic [DB-1:0]  r;
        logic [DB:0]    r2;
        logic [DB:0]    diff;
        n = d_num[j];
        r = d_rem[j];
        for (int i = 0; i < SER_DIGITS; i++) begin
          r2   = {r, n[PWP-1]};
          n    = {n[PWP-2:0], 1'b0};
          diff = r2 - {1'b0, dv};
          if (r2 >= {1'b0, dv}) begin
            r    = diff[DB-1:0];
            n[0] = 1'b1;
          end else begin
            r = r2[DB-1:0];
          end
        end
        num_nxt = n;
        rem_nxt = r;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r <= 1'b0;
        end else if (en) begin
          valid_r <= d_valid[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          num_r  <= num_nxt;
          rem_r  <= rem_nxt;
          sum_r  <= d_sum[j];
          q4_r   <= d_q4[j];
          side_r <= d_side[j];
        end
      end

      assign d_valid[j+1] = valid_r;
      assign d_num[j+1]   = num_r;
      assign d_rem[j+1]   = rem_r;
      assign d_sum[j+1]   = sum_r;
      assign d_q4[j+1]    = q4_r;
      assign d_side[j+1]  = side_r;
    end

    assign e_valid[k+1] = d_valid[NDS];
    assign e_term[k+1]  = TW'(d_num[NDS]);
    assign e_sum[k+1]   = d_sum[NDS];
    assign e_q4[k+1]    = d_q4[NDS];
    assign e_side[k+1]  = d_side[NDS];
  end

  logic            o_valid_r;
  logic [SUMW-1:0] o_sum_r;
  logic [SW-1:0]   o_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en) begin
      o_valid_r <= e_valid[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_sum_r  <= e_sum[NT] + SUMW'(e_term[NT]);
      o_side_r <= e_side[NT];
    end
  end

  assign out_valid = o_valid_r;
  assign sum       = o_sum_r;
  assign out_side  = o_side_r;

endmodule

`default_nettype wire

@@ hdl/kaiser_bessel_blob_eval.sv @@
// Kaiser-Bessel blob radial profile evaluator, fully pipelined, one radius per cycle
// while the output buffer has room; the series terms and both dividers are unrolled stages.
// A two-entry output buffer keeps input accepted while one result waits.
// Reset (rst_n, synchronous, active low) empties the pipe and loads register defaults.
`default_nettype none

module kaiser_bessel_blob_eval
  import kbb_pkg::*;
#(
  parameter int NUM_TERMS = NUM_TERMS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [21:0] radius
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [16:0] blob_value
  output logic [0:0]                  out_tuser,  // [0] outside_support
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int W    = FRAC_BITS;
  localparam int ZW   = W + 1;
  localparam int YW   = W + 5;
  localparam int SUMW = W + 20;
  localparam int ZS   = 2 * MAX_ORDER;
  localparam int UP   = (W > 16) ? W - 16 : 0;
  localparam int DN   = (W < 16) ? 16 - W : 0;
  localparam int AUW  = ALPHA_W + UP;
  localparam int VXW  = W + 1 + DN;

  // configuration registers
  logic [SR_W-1:0]    support_radius_r;
  logic [ORD_W-1:0]   bessel_order_r;
  logic [ALPHA_W-1:0] density_falloff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      support_radius_r  <= SR_RESET;
      bessel_order_r    <= ORD_RESET;
      density_falloff_r <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_SUPPORT_RADIUS:  support_radius_r  <= cfg_wdata[SR_W-1:0];
        CFG_BESSEL_ORDER:    bessel_order_r    <= cfg_wdata[ORD_W-1:0];
        CFG_DENSITY_FALLOFF: density_falloff_r <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // values derived from configuration, refreshed every cycle
  logic [A2_W-1:0]    a2_r;
  logic [YW-1:0]      alpha_w_r;
  logic [ALPHA_W-1:0] alpha_sat;
  logic [AUW-1:0]     alpha_up;

  assign alpha_sat = (density_falloff_r > ALPHA_MAX) ? ALPHA_MAX : density_falloff_r;
  assign alpha_up  = AUW'(alpha_sat) << UP;

  always_ff @(posedge clk) begin
    a2_r      <= A2_W'(support_radius_r) * A2_W'(support_radius_r);
    alpha_w_r <= YW'(alpha_up >> DN);
  end

  // output buffer occupancy sets the pipeline enable
  logic [1:0] cnt_r;
  logic       en;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  // stage 1: capture radius and support test
  logic              s1_valid_r;
  logic [SR_W-1:0]   s1_raw_r;
  logic              s1_out_r;
  logic              outside;

  assign outside = in_tdata[RADIUS_W-1] || (support_radius_r == '0) ||
                   (in_tdata[RADIUS_W-1:0] > {2'b00, support_radius_r});

  // stage 2: r^2, stage 3: a^2 - r^2
  logic              s2_valid_r;
  logic [A2_W-1:0]   s2_sq_r;
  logic              s2_out_r;
  logic              s3_valid_r;
  logic [A2_W-1:0]   s3_d_r;
  logic              s3_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw_r <= in_tdata[SR_W-1:0];
      s1_out_r <= outside;
      s2_sq_r  <= A2_W'(s1_raw_r) * A2_W'(s1_raw_r);
      s2_out_r <= s1_out_r;
      s3_d_r   <= a2_r - s2_sq_r;
      s3_out_r <= s2_out_r;
    end
  end

  // z^2 = (a^2 - r^2) / a^2 in Q.2W
  logic            z2_valid;
  logic [2*W:0]    z2;
  logic [0:0]      z2_out;

  kbb_frac_div #(
    .NW  (A2_W),
    .FB  (2 * W),
    .SPS (DIV_SPS),
    .SW  (1)
  ) u_zdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .num       (s3_d_r),
    .den       (a2_r),
    .in_side   (s3_out_r),
    .out_valid (z2_valid),
    .quo       (z2),
    .out_side  (z2_out)
  );

  logic          z_valid;
  logic [ZW-1:0] z;
  logic [0:0]    z_out;

  kbb_sqrt #(
    .FRAC_BITS (W),
    .SW        (1)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (z2_valid),
    .val       (z2),
    .in_side   (z2_out),
    .out_valid (z_valid),
    .root      (z),
    .out_side  (z_out)
  );

  // y = alpha * z
  logic          y_valid_r;
  logic [YW-1:0] y_y_r;
  logic [ZW-1:0] y_z_r;
  logic          y_out_r;
  logic [YW+ZW-1:0] yprod;

  assign yprod = (YW+ZW)'(alpha_w_r) * (YW+ZW)'(z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
    end else if (en) begin
      y_valid_r <= z_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_y_r   <= YW'(yprod >> W);
      y_z_r   <= z;
      y_out_r <= z_out[0];
    end
  end

  // z^(2m): one truncating multiply per stage, skipped past 2m
  logic          p_valid [ZS+1];
  logic [ZW-1:0] p_zp    [ZS+1];
  logic [ZW-1:0] p_z     [ZS+1];
  logic [YW-1:0] p_y     [ZS+1];
  logic          p_out   [ZS+1];

  assign p_valid[0] = y_valid_r;
  assign p_zp[0]    = ZW'(1) << W;
  assign p_z[0]     = y_z_r;
  assign p_y[0]     = y_y_r;
  assign p_out[0]   = y_out_r;

  for (genvar i = 0; i < ZS; i++) begin : g_zpow
    localparam logic [ORD_W:0] IDX = (ORD_W+1)'(i);

    logic            valid_r;
    logic [ZW-1:0]   zp_r;
    logic [ZW-1:0]   z_r;
    logic [YW-1:0]   y_r;
    logic            out_r;
    logic [2*ZW-1:0] mul;

    assign mul = (2*ZW)'(p_zp[i]) * (2*ZW)'(p_z[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r <= 1'b0;
      end else if (en) begin
        valid_r <= p_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zp_r  <= (IDX < {bessel_order_r, 1'b0}) ? ZW'(mul >> W) : p_zp[i];
        z_r   <= p_z[i];
        y_r   <= p_y[i];
        out_r <= p_out[i];
      end
    end

    assign p_valid[i+1] = valid_r;
    assign p_zp[i+1]    = zp_r;
    assign p_z[i+1]     = z_r;
    assign p_y[i+1]     = y_r;
    assign p_out[i+1]   = out_r;
  end

  // numerator and denominator series run side by side
  logic            sn_valid;
  logic [SUMW-1:0] s_num;
  logic [ZW-1:0]   sn_zp;
  logic            sd_valid;
  logic [SUMW-1:0] s_den;
  logic [0:0]      sd_out;

  kbb_series #(
    .FRAC_BITS (W),
    .NUM_TERMS (NUM_TERMS),
    .SW        (ZW)
  ) u_ser_num (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .order     (bessel_order_r),
    .in_valid  (p_valid[ZS]),
    .y         (p_y[ZS]),
    .in_side   (p_zp[ZS]),
    .out_valid (sn_valid),
    .sum       (s_num),
    .out_side  (sn_zp)
  );

  kbb_series #(
    .FRAC_BITS (W),
    .NUM_TERMS (NUM_TERMS),
    .SW        (1)
  ) u_ser_den (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .order     (bessel_order_r),
    .in_valid  (p_valid[ZS]),
    .y         (alpha_w_r),
    .in_side   (p_out[ZS]),
    .out_valid (sd_valid),
    .sum       (s_den),
    .out_side  (sd_out)
  );

  // ratio S(alpha z) / S(alpha), numerator clamped to the denominator
  logic [SUMW-1:0] s_num_c;
  logic            r_valid;
  logic [W:0]      ratio;
  logic [ZW:0]     r_side;

  assign s_num_c = (s_num > s_den) ? s_den : s_num;

  kbb_frac_div #(
    .NW  (SUMW),
    .FB  (W),
    .SPS (DIV_SPS),
    .SW  (ZW + 1)
  ) u_rdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sn_valid && sd_valid),
    .num       (s_num_c),
    .den       (s_den),
    .in_side   ({sn_zp, sd_out[0]}),
    .out_valid (r_valid),
    .quo       (ratio),
    .out_side  (r_side)
  );

  // final product
  logic            f1_valid_r;
  logic [2*ZW-1:0] f1_prod_r;
  logic            f1_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod_r <= (2*ZW)'(r_side[ZW:1]) * (2*ZW)'(ratio);
      f1_out_r  <= r_side[0];
    end
  end

  // scale to Q.16, saturate at one, and force zero outside the support
  logic [ZW-1:0]     val;
  logic [VXW-1:0]    val_s;
  logic [BLOB_W-1:0] blob;

  assign val   = ZW'(f1_prod_r >> W);
  assign val_s = (VXW'(val) >> UP) << DN;

  always_comb begin
    if (f1_out_r) begin
      blob = '0;
    end else if (val_s > VXW'(BLOB_ONE)) begin
      blob = BLOB_ONE;
    end else begin
      blob = BLOB_W'(val_s);
    end
  end

  // two-entry output buffer
  logic [BLOB_W-1:0] ent_blob_r [2];
  logic              ent_out_r  [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic              push;
  logic              pop;

  assign push = en && f1_valid_r;
  assign pop  = (cnt_r != 2'd0) && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_blob_r[wr_ptr_r] <= blob;
      ent_out_r[wr_ptr_r]  <= f1_out_r;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{(OUT_TDATA_W-BLOB_W){1'b0}}, ent_blob_r[rd_ptr_r]};
  assign out_tuser  = ent_out_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !out_tready) |=> (cnt_r == 2'd2))
    else $error("output buffer lost an item while full");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[BLOB_W-1:0] == '0))
    else $error("outside item carries nonzero value");

  a_blob_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[BLOB_W-1:0] <= BLOB_ONE))
    else $error("blob value above one");
`endif

endmodule

`default_nettype wire

@@ sim/kaiser_bessel_blob_eval_tb.sv @@
// Self-checking testbench for the Kaiser-Bessel blob radial profile evaluator.
`default_nettype none

class blob_scoreboard;
  localparam int FRAC = kbb_pkg::FRAC_BITS_DEF;
  localparam int TERMS = kbb_pkg::NUM_TERMS_DEF;
  localparam longint unsigned ONE = 64'd1 << FRAC;

  typedef struct {
    logic [kbb_pkg::BLOB_W-1:0] blob_value;
    logic                       outside_support;
  } profile_t;

  longint unsigned radius_a;
  longint unsigned order_m;
  longint unsigned falloff;
  profile_t        pending_profile[$];
  int              failures;

  function new();
    radius_a = kbb_pkg::SR_RESET;
    order_m  = kbb_pkg::ORD_RESET;
    falloff  = kbb_pkg::ALPHA_RESET;
    failures = 0;
  endfunction

  function void set_reg(kbb_pkg::cfg_idx_t idx, logic [kbb_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      kbb_pkg::CFG_SUPPORT_RADIUS:  radius_a = val[kbb_pkg::SR_W-1:0];
      kbb_pkg::CFG_BESSEL_ORDER:    order_m  = val[kbb_pkg::ORD_W-1:0];
      kbb_pkg::CFG_DENSITY_FALLOFF: falloff  = val[kbb_pkg::ALPHA_W-1:0];
      default: ;
    endcase
  endfunction

  // floor(n * 2^bits / d), bit-serial long division
  function longint unsigned scaled_quot(longint unsigned n, longint unsigned d, int bits);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Bessel series with the (y/2)^m/m! prefactor divided out
  function longint unsigned bessel_sum(longint unsigned y, longint unsigned m);
    longint unsigned q4, t, acc, hi, lo, prod;
    q4 = (y * y) >> (FRAC + 2);
    t = ONE;
    acc = 0;
    for (int k = 0; k < TERMS; k++) begin
      hi = t >> FRAC;
      lo = t & (ONE - 1);
      prod = hi * q4 + ((lo * q4) >> FRAC);
      acc = acc + t;
      t = prod / ((k + 1) * (k + m + 1));
    end
    return acc;
  endfunction

  function void note_radius(logic [kbb_pkg::RADIUS_W-1:0] radius);
    profile_t p;
    longint unsigned r, a2, z, alpha, y, s_num, s_den, zp, val;
    r = radius;
    if (radius[kbb_pkg::RADIUS_W-1] || radius_a == 0 || r > radius_a) begin
      p.blob_value = '0;
      p.outside_support = 1'b1;
    end else begin
      a2 = radius_a * radius_a;
      z = int_sqrt(scaled_quot(a2 - r * r, a2, 2 * FRAC));
      if (z > ONE) z = ONE;
      alpha = falloff > kbb_pkg::ALPHA_MAX ? kbb_pkg::ALPHA_MAX : falloff;
      y = (alpha * z) >> FRAC;
      s_num = bessel_sum(y, order_m);
      s_den = bessel_sum(alpha, order_m);
      zp = ONE;
      for (int i = 0; i < 2 * order_m; i++) zp = (zp * z) >> FRAC;
      if (s_num > s_den) s_num = s_den;
      val = (zp * scaled_quot(s_num, s_den, FRAC)) >> FRAC;
      if (val > kbb_pkg::BLOB_ONE) val = kbb_pkg::BLOB_ONE;
      p.blob_value = val[kbb_pkg::BLOB_W-1:0];
      p.outside_support = 1'b0;
    end
    pending_profile.push_back(p);
  endfunction

  function void check_result(logic [kbb_pkg::BLOB_W-1:0] blob_value, logic outside);
    profile_t p;
    if (pending_profile.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual value %0d outside %0b",
               $time, blob_value, outside);
      failures++;
      return;
    end
    p = pending_profile.pop_front();
    if (blob_value !== p.blob_value) begin
      $display("%0t: blob_value mismatch, expected %0d, actual %0d",
               $time, p.blob_value, blob_value);
      failures++;
    end
    if (outside !== p.outside_support) begin
      $display("%0t: outside_support mismatch, expected %0b, actual %0b",
               $time, p.outside_support, outside);
      failures++;
    end
  endfunction
endclass

module kaiser_bessel_blob_eval_tb;
  import kbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  blob_scoreboard profile_sb = new();
  bit calm = 1'b0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  kaiser_bessel_blob_eval i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Receiver: random backpressure, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready = calm ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      profile_sb.check_result(out_tdata[BLOB_W-1:0], out_tuser[0]);
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      quiet_cycles = quiet_cycles + 1;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_radius(logic [RADIUS_W-1:0] radius);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {{(IN_TDATA_W-RADIUS_W){1'b0}}, radius};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    profile_sb.note_radius(radius);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    if (idx != CFG_UNMAPPED) profile_sb.set_reg(cfg_idx_t'(idx), val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (profile_sb.pending_profile.size() != 0) @(negedge clk);
  endtask

  // Mostly radii inside the support, the rest anywhere in the field range
  function automatic logic [RADIUS_W-1:0] pick_radius(int unsigned a);
    if ($urandom_range(99) < 75) return RADIUS_W'($urandom_range(a, 0));
    return RADIUS_W'($urandom());
  endfunction

  task automatic run_phase(int unsigned a, int unsigned m, int unsigned alpha, int count);
    write_reg(CFG_SUPPORT_RADIUS, CFG_DATA_W'(a));
    write_reg(CFG_BESSEL_ORDER, CFG_DATA_W'(m));
    write_reg(CFG_DENSITY_FALLOFF, CFG_DATA_W'(alpha));
    send_radius(RADIUS_W'(0));
    send_radius(RADIUS_W'(a));
    send_radius(RADIUS_W'(a + 1));
    send_radius(RADIUS_W'(a / 2));
    for (int i = 0; i < count; i++) send_radius(pick_radius(a));
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults straight after reset, field extremes
    send_radius(RADIUS_W'(0));
    send_radius(RADIUS_W'(1));
    send_radius(RADIUS_W'(SR_RESET));
    send_radius(RADIUS_W'(SR_RESET + 1));
    send_radius({1'b1, {(RADIUS_W-1){1'b1}}});
    send_radius({1'b1, {(RADIUS_W-1){1'b0}}});
    send_radius({1'b0, {(RADIUS_W-1){1'b1}}});
    send_radius(RADIUS_W'(SR_RESET * 3 / 4));
    wait_drained();

    // ignored write, then check defaults still hold
    write_reg(CFG_UNMAPPED, '1);
    send_radius(RADIUS_W'(SR_RESET / 3));
    wait_drained();

    // alpha above the cap saturates; long receiver hold-off while the sender
    // keeps offering items past the pipe depth, so the input stalls
    hold_cycles = 700;
    run_phase(20'hFFFFF, 7, 21'h1FFFFF, 350);
    // zero alpha, order zero, smallest radius; no idling here
    calm = 1'b1;
    run_phase(1, 0, 0, 20);
    calm = 1'b0;
    // zero support radius: everything is outside
    run_phase(0, 3, 65536, 2);
    run_phase(SR_RESET, 2, ALPHA_MAX, 4);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(20'hFFFFF, 1), $urandom_range(MAX_ORDER, 0),
                $urandom_range(ALPHA_MAX, 0), 4);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (profile_sb.failures == 0 && profile_sb.pending_profile.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
